/* design/dfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared widths, parse phases and pipeline token types of the deduplicating
// frame deframer.
// ----------------------------------------------------------------------------
package dfd_pkg;

  localparam int BYTE_W = 8;
  localparam int SEQ_W  = 16;
  localparam int LEN_W  = 16;

  // Frame parser position
  typedef enum logic [2:0] {
    PH_SEQ_HI,
    PH_SEQ_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

  // What a byte means once it leaves the parser
  typedef enum logic [1:0] {
    TK_PASS,      // passthrough byte
    TK_HDR_TRUNC, // datagram ended inside a header
    TK_LEN,       // header complete, table lookup
    TK_PAY        // payload byte
  } tok_kind_t;

  typedef struct packed {
    logic              vld;
    tok_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              flag;  // TK_LEN: zero length, TK_PAY: final payload byte
    logic [SEQ_W-1:0]  seq;
  } tok_t;

endpackage
`default_nettype wire

/* design/dfd_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfd_in_if
// Received datagram byte channel, one byte per request.
// ----------------------------------------------------------------------------
interface dfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [dfd_pkg::BYTE_W-1:0] data_byte;
  logic                      datagram_last;

  modport source (output valid, output data_byte, output datagram_last, input ready);
  modport sink   (input valid, input data_byte, input datagram_last, output ready);
endinterface
`default_nettype wire

/* design/dfd_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfd_out_if
// Delivered payload channel with end, empty and truncation markers.
// ----------------------------------------------------------------------------
interface dfd_out_if;
  logic                      valid;
  logic                      ready;
  logic [dfd_pkg::BYTE_W-1:0] payload_byte;
  logic                      byte_valid;
  logic                      payload_last;
  logic                      empty_payload;
  logic                      truncated;

  modport source (output valid, output payload_byte, output byte_valid,
                  output payload_last, output empty_payload, output truncated,
                  input ready);
  modport sink   (input valid, input payload_byte, input byte_valid,
                  input payload_last, input empty_payload, input truncated,
                  output ready);
endinterface
`default_nettype wire

/* design/dedup_frame_deframer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_frame_deframer
// Parses sequence/length framed bytes, suppresses repeated sequence numbers
// through a table indexed by sequence modulo depth, or passes bytes through.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    data_byte, datagram_last
//  out_ch   out  valid/ready    payload_byte, byte_valid, payload_last,
//                               empty_payload, truncated
//  cfg_*    in   write enable   fec_enabled (1 bit)
//
//  One byte per cycle sustained while the output is not stalled. A result
//  passes s1 (product taken at acceptance), s2 (remainder), s3 (table read)
//  and the compare into the output register.
//  After reset the table is cleared one slot per cycle, with in_ch.ready low.
//  A stalled output freezes the whole pipeline; in_ch.ready is high whenever
//  the output register is empty or being taken and no clearing pass runs.
// ----------------------------------------------------------------------------
module dedup_frame_deframer #(
  parameter int SEQ_TABLE_DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dfd_in_if.sink     in_ch,
  dfd_out_if.source  out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);

  localparam int IDX_W = (SEQ_TABLE_DEPTH > 1) ? $clog2(SEQ_TABLE_DEPTH) : 1;
  localparam int REM_W = 18;
  localparam longint unsigned RECIP_L = (64'd1 << 32) / 64'(SEQ_TABLE_DEPTH);
  localparam logic [31:0] RECIP = 32'(RECIP_L);
  localparam logic [16:0] DEPTH_V = 17'(SEQ_TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_TABLE_DEPTH - 1);

  localparam int SW = dfd_pkg::SEQ_W;
  localparam int LW = dfd_pkg::LEN_W;
  localparam int BW = dfd_pkg::BYTE_W;

  // ------------------------------------------------------------------------
  // Configuration and clearing pass
  // ------------------------------------------------------------------------
  logic             fec_en_r;
  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fec_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      fec_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------------
  // Handshake: whole pipeline advances when the output register can load
  // ------------------------------------------------------------------------
  logic out_vld_r;
  logic adv;
  logic in_acc;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && !clr_busy_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // ------------------------------------------------------------------------
  // Frame parser
  // ------------------------------------------------------------------------
  dfd_pkg::phase_t phase_r, phase_nxt;
  logic [SW-1:0]   seq_r, seq_nxt;
  logic [LW-1:0]   rem_r, rem_nxt;
  logic [LW-1:0]   rem_dec;
  logic [LW-1:0]   len_full;
  logic [BW-1:0]   b;
  logic            blast;

  assign b        = in_ch.data_byte;
  assign blast    = in_ch.datagram_last;
  assign rem_dec  = rem_r - 1'b1;
  assign len_full = {rem_r[LW-1:BW], b};

  // Next parse state
  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    rem_nxt   = rem_r;
    if (!fec_en_r) begin
      phase_nxt = dfd_pkg::PH_SEQ_HI;
    end else begin
      case (phase_r)
        dfd_pkg::PH_SEQ_HI: begin
          seq_nxt   = {b, seq_r[BW-1:0] & 8'h00};
          phase_nxt = blast ? dfd_pkg::PH_SEQ_HI : dfd_pkg::PH_SEQ_LO;
        end
        dfd_pkg::PH_SEQ_LO: begin
          seq_nxt   = {seq_r[SW-1:BW], b};
          phase_nxt = blast ? dfd_pkg::PH_SEQ_HI : dfd_pkg::PH_LEN_HI;
        end
        dfd_pkg::PH_LEN_HI: begin
          rem_nxt   = {b, {BW{1'b0}}};
          phase_nxt = blast ? dfd_pkg::PH_SEQ_HI : dfd_pkg::PH_LEN_LO;
        end
        dfd_pkg::PH_LEN_LO: begin
          rem_nxt = len_full;
          if (len_full == '0 || blast) begin
            phase_nxt = dfd_pkg::PH_SEQ_HI;
          end else begin
            phase_nxt = dfd_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0 || blast) begin
            phase_nxt = dfd_pkg::PH_SEQ_HI;
          end else begin
            phase_nxt = dfd_pkg::PH_PAYLOAD;
          end
        end
      endcase
    end
  end

  // Token for the accepted byte
  dfd_pkg::tok_t in_tok;

  always_comb begin
    in_tok      = '0;
    in_tok.vld  = in_acc;
    in_tok.data = b;
    in_tok.last = blast;
    in_tok.seq  = seq_r;
    in_tok.kind = dfd_pkg::TK_PASS;
    if (fec_en_r) begin
      case (phase_r)
        dfd_pkg::PH_SEQ_HI, dfd_pkg::PH_SEQ_LO, dfd_pkg::PH_LEN_HI: begin
          // header bytes give a result only when the datagram ends here
          in_tok.kind = dfd_pkg::TK_HDR_TRUNC;
          in_tok.vld  = in_acc && blast;
        end
        dfd_pkg::PH_LEN_LO: begin
          in_tok.kind = dfd_pkg::TK_LEN;
          in_tok.flag = (len_full == '0);
        end
        default: begin
          in_tok.kind = dfd_pkg::TK_PAY;
          in_tok.flag = (rem_dec == '0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dfd_pkg::PH_SEQ_HI;
      seq_r   <= '0;
      rem_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // ------------------------------------------------------------------------
  // Slot = seq mod depth: reciprocal product, remainder, one correction
  // ------------------------------------------------------------------------
  dfd_pkg::tok_t     s1_tok_r, s2_tok_r, s3_tok_r;
  logic [47:0]       s1_prod_r;
  logic [REM_W-1:0]  s2_rem_r;
  logic [32:0]       qd;
  logic [REM_W-1:0]  rem_fix;
  logic [IDX_W-1:0]  rd_slot;
  logic [IDX_W-1:0]  s3_slot_r;
  logic [SW-1:0]     rd_data_r;

  assign qd      = s1_prod_r[47:32] * DEPTH_V;
  assign rem_fix = (s2_rem_r >= REM_W'(DEPTH_V)) ? (s2_rem_r - REM_W'(DEPTH_V)) : s2_rem_r;
  assign rd_slot = rem_fix[IDX_W-1:0];

  // Advance the pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r.vld <= 1'b0;
      s2_tok_r.vld <= 1'b0;
      s3_tok_r.vld <= 1'b0;
    end else if (adv) begin
      s1_tok_r <= in_tok;
      s2_tok_r <= s1_tok_r;
      s3_tok_r <= s2_tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= 48'(seq_r) * 48'(RECIP);
      s2_rem_r  <= REM_W'(s1_tok_r.seq) - qd[REM_W-1:0];
      s3_slot_r <= rd_slot;
    end
  end

  // ------------------------------------------------------------------------
  // Seen-sequence table
  // ------------------------------------------------------------------------
  logic [SW-1:0] seen_mem [SEQ_TABLE_DEPTH];
  logic          deliver;
  logic          tbl_wr;

  assign deliver = (rd_data_r != s3_tok_r.seq);
  assign tbl_wr  = adv && s3_tok_r.vld && (s3_tok_r.kind == dfd_pkg::TK_LEN) && deliver;

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      seen_mem[clr_idx_r] <= '0;
    end else if (tbl_wr) begin
      seen_mem[s3_slot_r] <= s3_tok_r.seq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= seen_mem[rd_slot];
    end
  end

  // ------------------------------------------------------------------------
  // Result formation and output register
  // ------------------------------------------------------------------------
  logic          dlv_r, dlv_nxt;
  logic          res;
  logic [BW-1:0] res_byte;
  logic          res_bvld;
  logic          res_last;
  logic          res_empty;
  logic          res_trunc;

  always_comb begin
    res       = 1'b0;
    res_byte  = '0;
    res_bvld  = 1'b0;
    res_last  = 1'b0;
    res_empty = 1'b0;
    res_trunc = 1'b0;
    dlv_nxt   = dlv_r;
    case (s3_tok_r.kind)
      dfd_pkg::TK_PASS: begin
        res      = 1'b1;
        res_byte = s3_tok_r.data;
        res_bvld = 1'b1;
        res_last = s3_tok_r.last;
      end
      dfd_pkg::TK_HDR_TRUNC: begin
        res       = 1'b1;
        res_trunc = 1'b1;
      end
      dfd_pkg::TK_LEN: begin
        dlv_nxt = deliver;
        if (s3_tok_r.flag) begin
          res       = deliver;
          res_last  = 1'b1;
          res_empty = 1'b1;
        end else if (s3_tok_r.last) begin
          res       = 1'b1;
          res_trunc = 1'b1;
        end
      end
      default: begin
        if (s3_tok_r.last && !s3_tok_r.flag) begin
          res       = 1'b1;
          res_trunc = 1'b1;
          res_bvld  = dlv_r;
          res_byte  = dlv_r ? s3_tok_r.data : '0;
        end else if (dlv_r) begin
          res      = 1'b1;
          res_bvld = 1'b1;
          res_byte = s3_tok_r.data;
          res_last = s3_tok_r.flag;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dlv_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s3_tok_r.vld && res;
      if (s3_tok_r.vld) begin
        dlv_r <= dlv_nxt;
      end
    end
  end

  logic [BW-1:0] out_byte_r;
  logic          out_bvld_r;
  logic          out_last_r;
  logic          out_empty_r;
  logic          out_trunc_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r  <= res_byte;
      out_bvld_r  <= res_bvld;
      out_last_r  <= res_last;
      out_empty_r <= res_empty;
      out_trunc_r <= res_trunc;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_byte  = out_byte_r;
  assign out_ch.byte_valid    = out_bvld_r;
  assign out_ch.payload_last  = out_last_r;
  assign out_ch.empty_payload = out_empty_r;
  assign out_ch.truncated     = out_trunc_r;

endmodule
`default_nettype wire

/* test/dfd_delivery_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_delivery_check
// Watches the byte and payload channels of the deduplicating frame deframer,
// predicts every delivery from the accepted bytes and compares field by field.
// ----------------------------------------------------------------------------
module dfd_delivery_check #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic clk,
  input  logic rst_n,
  dfd_in_if    in_ch,
  dfd_out_if   out_ch,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [dfd_pkg::BYTE_W-1:0] payload_byte;
    logic                       byte_valid;
    logic                       payload_last;
    logic                       empty_payload;
    logic                       truncated;
  } delivery_t;

  delivery_t expected_deliveries[$];

  // Predicted deframer state
  logic                      fec_on;
  dfd_pkg::phase_t           phase;
  logic [dfd_pkg::SEQ_W-1:0] frame_seq;
  logic [dfd_pkg::LEN_W-1:0] remaining;
  logic                      deliver;
  logic [dfd_pkg::SEQ_W-1:0] seen_table [TABLE_DEPTH];

  int err_count    = 0;
  int result_count = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH result %0d at %0t: %s", result_count, $realtime, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Advance the parser by one received byte; return 1 when it delivers
  function automatic bit deframe_byte(input logic [dfd_pkg::BYTE_W-1:0] b,
                                      input logic last, output delivery_t d);
    int   slot;
    logic done;
    d = '0;
    if (!fec_on) begin
      phase          = dfd_pkg::PH_SEQ_HI;
      d.payload_byte = b;
      d.byte_valid   = 1'b1;
      d.payload_last = last;
      return 1'b1;
    end
    case (phase)
      dfd_pkg::PH_SEQ_HI: begin
        frame_seq = {b, 8'h00};
        phase     = dfd_pkg::PH_SEQ_LO;
      end
      dfd_pkg::PH_SEQ_LO: begin
        frame_seq[7:0] = b;
        phase          = dfd_pkg::PH_LEN_HI;
      end
      dfd_pkg::PH_LEN_HI: begin
        remaining = {b, 8'h00};
        phase     = dfd_pkg::PH_LEN_LO;
      end
      dfd_pkg::PH_LEN_LO: begin
        slot           = int'(frame_seq) % TABLE_DEPTH;
        remaining[7:0] = b;
        deliver        = (seen_table[slot] != frame_seq);
        if (deliver) seen_table[slot] = frame_seq;
        if (remaining == '0) begin
          phase = dfd_pkg::PH_SEQ_HI;
          if (deliver) begin
            d.payload_last  = 1'b1;
            d.empty_payload = 1'b1;
            return 1'b1;
          end
          return 1'b0;
        end
        phase = dfd_pkg::PH_PAYLOAD;
        if (last) begin
          phase       = dfd_pkg::PH_SEQ_HI;
          d.truncated = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        remaining = remaining - 1'b1;
        done      = (remaining == '0);
        if (done) phase = dfd_pkg::PH_SEQ_HI;
        // Datagram ended before the payload did
        if (last && !done) begin
          phase       = dfd_pkg::PH_SEQ_HI;
          d.truncated = 1'b1;
          if (deliver) begin
            d.payload_byte = b;
            d.byte_valid   = 1'b1;
          end
          return 1'b1;
        end
        if (deliver) begin
          d.payload_byte = b;
          d.byte_valid   = 1'b1;
          d.payload_last = done;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
    // Datagram ended inside the header
    if (last) begin
      phase       = dfd_pkg::PH_SEQ_HI;
      d.truncated = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    delivery_t got;
    delivery_t want;
    delivery_t pred;
    if (!rst_n) begin
      fec_on    = 1'b0;
      phase     = dfd_pkg::PH_SEQ_HI;
      frame_seq = '0;
      remaining = '0;
      deliver   = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) seen_table[i] = '0;
      expected_deliveries.delete();
    end else begin
      // Compare a taken result with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.payload_byte, out_ch.byte_valid, out_ch.payload_last,
                out_ch.empty_payload, out_ch.truncated};
        if (expected_deliveries.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_deliveries.pop_front();
          check_field("payload_byte", got.payload_byte, want.payload_byte);
          check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
          check_field("payload_last", 8'(got.payload_last), 8'(want.payload_last));
          check_field("empty_payload", 8'(got.empty_payload),
                      8'(want.empty_payload));
          check_field("truncated", 8'(got.truncated), 8'(want.truncated));
        end
        result_count++;
      end
      // Track the mode register
      if (cfg_wr_en) fec_on = cfg_wr_data;
      // Predict from an accepted byte
      if (in_ch.valid && in_ch.ready) begin
        if (deframe_byte(in_ch.data_byte, in_ch.datagram_last, pred))
          expected_deliveries.push_back(pred);
      end
    end
    mismatches  <= err_count;
    outstanding <= expected_deliveries.size();
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives datagrams into the deduplicating frame deframer in passthrough and
// framed mode under several idle and stall profiles and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH       = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 12;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;

  typedef logic [dfd_pkg::BYTE_W-1:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  dfd_in_if  in_ch ();
  dfd_out_if out_ch ();

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;

  logic [dfd_pkg::SEQ_W-1:0] recent_seqs[$];

  always #5 clk = ~clk;

  dedup_frame_deframer #(.SEQ_TABLE_DEPTH(DEPTH)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  dfd_delivery_check #(.TABLE_DEPTH(DEPTH)) u_delivery_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_done;
    int hold_left;
    hold_done = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one byte, idling first at random, and hold until taken
  task automatic send_byte(input logic [dfd_pkg::BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.datagram_last <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_datagram(input byte_q_t bytes_q);
    for (int i = 0; i < bytes_q.size(); i++)
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_fec(input logic en);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Pick a sequence number: repeats, small values, same slot, or fresh
  function automatic logic [dfd_pkg::SEQ_W-1:0] pick_seq();
    logic [dfd_pkg::SEQ_W-1:0] s;
    int                        r;
    r = $urandom_range(99);
    if (r < 35 && recent_seqs.size() > 0)
      s = recent_seqs[$urandom_range(recent_seqs.size() - 1)];
    else if (r < 45)
      s = dfd_pkg::SEQ_W'($urandom_range(3));
    else if (r < 55 && recent_seqs.size() > 0)
      s = {8'($urandom), recent_seqs[$urandom_range(recent_seqs.size() - 1)][7:0]};
    else
      s = dfd_pkg::SEQ_W'($urandom);
    recent_seqs.push_back(s);
    if (recent_seqs.size() > 16) void'(recent_seqs.pop_front());
    return s;
  endfunction

  function automatic void push_header(ref byte_q_t q,
                                      input logic [dfd_pkg::SEQ_W-1:0] s,
                                      input logic [dfd_pkg::LEN_W-1:0] len);
    q.push_back(s[15:8]);
    q.push_back(s[7:0]);
    q.push_back(len[15:8]);
    q.push_back(len[7:0]);
  endfunction

  // Build a framed datagram: mostly well formed, some cut short or noise
  function automatic byte_q_t make_framed_datagram();
    byte_q_t                   q;
    int                        r;
    int                        kind;
    int                        len;
    logic [dfd_pkg::LEN_W-1:0] huge;
    q    = {};
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 10)) q.push_back(8'($urandom));
      return q;
    end
    repeat ($urandom_range(1, 3)) begin
      r = $urandom_range(99);
      if (r < 10)      len = 0;
      else if (r < 85) len = $urandom_range(1, 8);
      else if (r < 95) len = $urandom_range(9, 24);
      else             len = $urandom_range(25, 40);
      push_header(q, pick_seq(), dfd_pkg::LEN_W'(len));
      repeat (len) q.push_back(8'($urandom));
    end
    if (kind < 12) begin
      // Huge length that the datagram never completes
      huge = dfd_pkg::LEN_W'($urandom);
      if (huge < 16'd8) huge = 16'hFFFF;
      push_header(q, pick_seq(), huge);
      repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
    end else if (kind < 28) begin
      // Cut anywhere, header or payload or on a boundary
      if (q.size() > 1) q = q[0:$urandom_range(q.size() - 2)];
    end
    return q;
  endfunction

  initial begin
    byte_q_t dgram;
    int      phase_sent;
    logic    fec_sel;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.datagram_last <= 1'b0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= 1'b0;
    rst_n               <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Passthrough straight out of reset
    send_datagram('{8'h00, 8'hFF});
    drain();
    write_fec(1'b1);
    // Sequence zero is dropped, empty frame marker, two-byte payload
    send_datagram('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00,
                    8'hFF, 8'h01, 8'h00, 8'h02, 8'hAA, 8'h55});
    // Ends inside a header
    send_datagram('{8'h12});
    // Ends right after a header with nonzero length
    send_datagram('{8'h00, 8'h07, 8'h00, 8'h03});
    // Ends inside a delivered payload
    send_datagram('{8'h01, 8'h07, 8'h00, 8'h03, 8'h80});

    for (int p = 0; p < PHASES; p++) begin
      drain();
      fec_sel = !(p == 2 || p == 5);
      write_fec(fec_sel);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 45; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 45; end
        default: begin idle_pct = 14; stall_pct <= 14; end
      endcase
      // Long receiver hold-off while the sender keeps offering
      if (p == 0) hold_req <= hold_req + 1;
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS) begin
        if (fec_sel) begin
          dgram = make_framed_datagram();
        end else begin
          dgram = {};
          repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
        end
        send_datagram(dgram);
        phase_sent += dgram.size();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
